@@ sv/dns_relay_id_translation_table_defines.svh @@
// Assertion macros used by the checker file drt_checker.sv
`ifndef DNS_RELAY_ID_TRANSLATION_TABLE_DEFINES_SVH
`define DNS_RELAY_ID_TRANSLATION_TABLE_DEFINES_SVH

// Check that a property holds on every clock edge outside reset
`define DRT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property that also holds during reset
`define DRT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/drt_pkg.sv @@
package drt_pkg;

  localparam int unsigned SLOTS_DEFAULT = 32;
  localparam int unsigned HEADER_BYTES  = 12;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5;
  localparam logic [15:0] ID_RESET      = 16'd1;

  typedef enum logic [1:0] {
    CMD_FORWARD  = 2'd0,
    CMD_RESPONSE = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FORWARDED = 3'd0,
    ST_MATCHED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_SHORT     = 3'd4,
    ST_TICK_DONE = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] packet_id;
    logic [15:0] packet_length;
    logic [47:0] client_address;
    logic [7:0]  client_address_length;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_id;
    logic [47:0] return_address;
    logic [7:0]  return_address_length;
    logic [5:0]  expired_count;
  } rsp_t;

endpackage

@@ sv/drt_if.sv @@
interface drt_req_if;
  logic           valid;
  logic           ready;
  drt_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface drt_rsp_if;
  logic           valid;
  logic           ready;
  drt_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/drt_ram.sv @@
module drt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/dns_relay_id_translation_table.sv @@
// Channel   Direction  Payload
// req       in         command, packet_id, packet_length, client_address, ..._length
// rsp       out        status, result_id, return_address, ..._length, expired_count
// Forward: a search of the valid bits for the lowest free slot, then one scan of all
//   slots per drawn ID, through one registered RAM read port, until the ID is unused.
// Response and tick: one scan of all slots; short forward and response packets skip it.
// rst is synchronous; it clears the valid bits and seconds counter, sets the ID counter to 1.
// The block takes no request while one is in work or its result waits on rsp.
module dns_relay_id_translation_table #(
  parameter int unsigned SLOTS = drt_pkg::SLOTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  drt_req_if.sink         req,
  drt_rsp_if.source       rsp,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata
);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = 16 + 16 + 48 + 8 + 32;

  typedef enum logic [2:0] {
    S_IDLE, S_FREE, S_SCAN, S_READ, S_DONE
  } state_t;

  state_t         state;
  drt_pkg::req_t  cur;
  logic [15:0]    timeout;
  logic [15:0]    next_id;
  logic [31:0]    now_seconds;
  logic [SLOTS-1:0] valid_bits;
  logic [CW-1:0]  idx;
  logic [AW-1:0]  hit_slot;
  logic [AW-1:0]  free_slot;
  logic [15:0]    proxy;
  logic           conflict;
  logic [5:0]     cnt;
  logic           rd_pend;
  logic [AW-1:0]  rd_slot;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [EW-1:0]  wdata;
  logic [AW-1:0]  raddr;
  logic [EW-1:0]  rdata;

  logic [15:0] e_proxy, e_orig;
  logic [47:0] e_client;
  logic [7:0]  e_len;
  logic [31:0] e_stamp;
  logic [15:0] id_inc;

  assign {e_proxy, e_orig, e_client, e_len, e_stamp} = rdata;
  assign raddr  = idx[AW-1:0];
  assign id_inc = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;

  drt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign req.ready = (state == S_IDLE) && !rsp.valid;

  always_comb begin
    we    = (state == S_SCAN) && !rd_pend && !conflict && (idx == CW'(SLOTS))
            && (cur.command == drt_pkg::CMD_FORWARD);
    waddr = free_slot;
    wdata = {proxy, cur.packet_id, cur.client_address, cur.client_address_length,
             now_seconds};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      timeout     <= drt_pkg::TIMEOUT_RESET;
      next_id     <= drt_pkg::ID_RESET;
      now_seconds <= '0;
      valid_bits  <= '0;
      rsp.valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      // RAM read of slot idx returns next cycle; rd_pend marks it
      rd_pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur      <= req.data;
            idx      <= '0;
            conflict <= 1'b0;
            hit_slot <= '0;
            cnt      <= '0;
            if ((req.data.command == drt_pkg::CMD_FORWARD ||
                 req.data.command == drt_pkg::CMD_RESPONSE) &&
                req.data.packet_length < 16'(drt_pkg::HEADER_BYTES)) begin
              rsp.data <= '{status: drt_pkg::ST_SHORT, default: '0};
              state <= S_DONE;
            end else if (req.data.command == drt_pkg::CMD_FORWARD) begin
              rsp.data <= '0;
              state <= S_FREE;
            end else if (req.data.command == drt_pkg::CMD_TICK) begin
              rsp.data <= '0;
              now_seconds <= now_seconds + 32'd1;
              state <= S_SCAN;
            end else if (req.data.command == drt_pkg::CMD_RESPONSE) begin
              rsp.data <= '0;
              state <= S_SCAN;
            end else begin
              rsp.data <= '{status: drt_pkg::ST_TICK_DONE, default: '0};
              state <= S_DONE;
            end
          end
        end
        S_FREE: begin
          // lowest free slot, one bit a cycle
          if (idx == CW'(SLOTS)) begin
            rsp.data.status <= drt_pkg::ST_FULL;
            state <= S_DONE;
          end else if (!valid_bits[idx[AW-1:0]]) begin
            free_slot <= idx[AW-1:0];
            proxy     <= next_id;
            next_id   <= id_inc;
            idx       <= '0;
            state     <= S_SCAN;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SCAN: begin
          if (rd_pend && valid_bits[rd_slot]) begin
            case (cur.command)
              drt_pkg::CMD_FORWARD: begin
                if (e_proxy == proxy) conflict <= 1'b1;
              end
              drt_pkg::CMD_RESPONSE: begin
                if (e_proxy == cur.packet_id && !conflict) begin
                  conflict <= 1'b1;
                  hit_slot <= rd_slot;
                  rsp.data.result_id <= e_orig;
                  rsp.data.return_address <= e_client;
                  rsp.data.return_address_length <= e_len;
                end
              end
              default: begin
                if ((now_seconds - e_stamp) >= {16'd0, timeout}) begin
                  valid_bits[rd_slot] <= 1'b0;
                  if (cnt != 6'd63) cnt <= cnt + 6'd1;
                end
              end
            endcase
          end
          if (idx != CW'(SLOTS)) begin
            rd_pend <= 1'b1;
            rd_slot <= idx[AW-1:0];
            idx     <= idx + CW'(1);
          end else if (!rd_pend) begin
            case (cur.command)
              drt_pkg::CMD_FORWARD: begin
                if (conflict) begin
                  proxy    <= next_id;
                  next_id  <= id_inc;
                  conflict <= 1'b0;
                  idx      <= '0;
                end else begin
                  valid_bits[free_slot] <= 1'b1;
                  rsp.data.status    <= drt_pkg::ST_FORWARDED;
                  rsp.data.result_id <= proxy;
                  state <= S_DONE;
                end
              end
              drt_pkg::CMD_RESPONSE: begin
                if (conflict) begin
                  valid_bits[hit_slot] <= 1'b0;
                  rsp.data.status <= drt_pkg::ST_MATCHED;
                end else begin
                  rsp.data.status <= drt_pkg::ST_UNKNOWN;
                end
                state <= S_DONE;
              end
              default: begin
                rsp.data.status <= drt_pkg::ST_TICK_DONE;
                rsp.data.expired_count <= cnt;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          rsp.valid <= 1'b1;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/drt_checker.sv @@
`include "dns_relay_id_translation_table_defines.svh"

module drt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input drt_pkg::rsp_t  rsp_data
);
  `DRT_ASSERT(a_no_accept_while_out, clk, rst, rsp_valid |-> !req_ready, "ready while result waits")
  `DRT_ASSERT(a_out_stable, clk, rst, (rsp_valid && !rsp_ready) |=> $stable(rsp_data), "result changed while stalled")
  `DRT_ASSERT(a_status_range, clk, rst, rsp_valid |-> (rsp_data.status <= 3'd5), "bad status")
  `DRT_ASSERT(a_fwd_nonzero, clk, rst, (rsp_valid && rsp_data.status == drt_pkg::ST_FORWARDED) |-> (rsp_data.result_id != 16'd0), "proxy id zero")
  `DRT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !rsp_valid, "result after reset")
endmodule

bind dns_relay_id_translation_table drt_checker u_drt_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
